### hdl/svpwm_compare_generator_macros.svh
// Assertion macros for the SVPWM compare generator RTL.
`ifndef SVPWM_COMPARE_GENERATOR_MACROS_SVH
`define SVPWM_COMPARE_GENERATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SVCG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svpwm compare generator: same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define SVCG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svpwm compare generator: next-cycle check failed");

`endif

### hdl/svcg_pkg.sv
// Package with the constants, types and helper functions of the SVPWM compare generator.
`default_nettype none

package svcg_pkg;

  // Angle resolution and CORDIC depth.
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int TBL_LEN       = 24;
  localparam int TBL_IDX_W     = 5;
  localparam int IDX_W         = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

  // Field widths.
  localparam int VIN_W  = 17;
  localparam int BUS_W  = 16;
  localparam int CFG_W  = 16;
  localparam int TURN_W = 32;

  // CORDIC datapath: input magnitude up to 2^16, scaled and grown by the gain.
  localparam int XY_W = VIN_W + CORDIC_STAGES + 2;

  // Projection, duty and time widths.
  localparam int FRAC_BITS = 8;
  localparam int PROJ_W    = 37;
  localparam int Q_W       = 35;
  localparam int QL_W      = 18;
  localparam int QH_W      = Q_W - QL_W;
  localparam int D_W       = 36;
  localparam int TIME_W    = CFG_W + FRAC_BITS;

  // Bus shift that scales millivolts into projection units.
  localparam int BUS_SHIFT = 17;

  // Stream widths.
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 152;

  localparam logic [17:0]      SQRT3_Q16  = 18'd113512;
  localparam logic [BUS_W-1:0] LOW_BUS_MV = 16'd100;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_PERIOD = 3'd0,
    CFG_MIN    = 3'd1,
    CFG_MAX    = 3'd2,
    CFG_TRIG   = 3'd3,
    CFG_DEFBUS = 3'd4
  } cfg_idx_t;

  // Trusted phase pair codes.
  typedef enum logic [1:0] {
    PAIR_VW = 2'd0,
    PAIR_UW = 2'd1,
    PAIR_UV = 2'd2
  } pair_t;

  // Beat carried along the CORDIC cells.
  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic [TURN_W-1:0]       z;
    logic signed [VIN_W-1:0] a;
    logic signed [VIN_W-1:0] b;
    logic [BUS_W-1:0]        bus;
  } cordic_t;

  // Beat carried along the divider cells: two division lanes sharing a divisor.
  typedef struct packed {
    logic [D_W-1:0]    rem1;
    logic [D_W-1:0]    rem2;
    logic [D_W-1:0]    dvs;
    logic [TIME_W-1:0] nq1;
    logic [TIME_W-1:0] nq2;
    logic [2:0]        sector;
  } div_t;

  // Arctangent of 2^-i as a fraction of a full turn, 2^32 units per turn.
  function automatic logic [TURN_W-1:0] atan_turn(input logic [TBL_IDX_W-1:0] idx);
    logic [TURN_W-1:0] r;
    case (idx)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Clamp to the compare range; the minimum is tested before the maximum.
  function automatic logic [CFG_W-1:0] clamp_cmp(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] mn,
                                                 input logic [CFG_W-1:0] mx);
    logic [CFG_W-1:0] r;
    if (v < mn) begin
      r = mn;
    end else if (v > mx) begin
      r = mx;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/svcg_cordic_cell.sv
// One vectoring CORDIC iteration with its own beat register and handshake.
`default_nettype none

module svcg_cordic_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [svcg_pkg::IDX_W-1:0]   stage_idx,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire svcg_pkg::cordic_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output svcg_pkg::cordic_t                 out_data
);
  import svcg_pkg::*;

  logic                    valid_r;
  cordic_t                 data_r;
  cordic_t                 data_nxt;
  logic signed [XY_W-1:0]  x_sh;
  logic signed [XY_W-1:0]  y_sh;
  logic [TURN_W-1:0]       step_ang;

  // Rotate towards the x axis by the arctangent of this stage.
  always_comb begin
    x_sh     = in_data.x >>> stage_idx;
    y_sh     = in_data.y >>> stage_idx;
    step_ang = atan_turn(TBL_IDX_W'(stage_idx));
    data_nxt = in_data;
    if (!in_data.y[XY_W-1]) begin
      data_nxt.x = in_data.x + y_sh;
      data_nxt.y = in_data.y - x_sh;
      data_nxt.z = in_data.z + step_ang;
    end else begin
      data_nxt.x = in_data.x - y_sh;
      data_nxt.y = in_data.y + x_sh;
      data_nxt.z = in_data.z - step_ang;
    end
  end

  // The cell takes a beat whenever it is empty or its neighbour takes its beat.
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

### hdl/svcg_div_cell.sv
// One restoring division step for two lanes sharing a divisor, with its own beat register.
`default_nettype none

module svcg_div_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire svcg_pkg::div_t    in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output svcg_pkg::div_t         out_data
);
  import svcg_pkg::*;

  logic           valid_r;
  div_t           data_r;
  div_t           data_nxt;
  logic [D_W:0]   trial1;
  logic [D_W:0]   trial2;
  logic [D_W:0]   dvs_ext;
  logic           qbit1;
  logic           qbit2;

  // Shift the next dividend bit into each remainder and subtract where it fits.
  always_comb begin
    dvs_ext  = {1'b0, in_data.dvs};
    trial1   = {in_data.rem1, in_data.nq1[TIME_W-1]};
    trial2   = {in_data.rem2, in_data.nq2[TIME_W-1]};
    qbit1    = (trial1 >= dvs_ext);
    qbit2    = (trial2 >= dvs_ext);
    data_nxt = in_data;
    data_nxt.rem1 = qbit1 ? D_W'(trial1 - dvs_ext) : trial1[D_W-1:0];
    data_nxt.rem2 = qbit2 ? D_W'(trial2 - dvs_ext) : trial2[D_W-1:0];
    data_nxt.nq1  = {in_data.nq1[TIME_W-2:0], qbit1};
    data_nxt.nq2  = {in_data.nq2[TIME_W-2:0], qbit2};
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

### hdl/svpwm_compare_generator.sv
// Top level of the seven-segment space vector PWM compare generator.
//
// Input stream: one beat per command, carrying the alpha and beta voltages and the
// measured bus voltage. Output stream: one beat per command with the sector, the
// active and zero times, the clamped phase compares, the two sampling windows, the
// ADC trigger compare, the midpoint flag and the trusted phase pair.
// Configuration is a plain write port (period, compare limits, trigger offset and
// default bus); writes land at the clock edge with the write enable high.
// The path from an accepted input beat to out_tvalid runs through an input stage,
// a CORDIC cell per iteration, stages A, B, M and N for sector, projection and
// multiply, a divider cell per quotient bit, and stage F and the output register
// for compare arithmetic.
// Throughput is one beat per cycle; every stage is a register with its own valid
// bit, so a new beat enters each cycle while the chain keeps flowing.
// When the receiver stalls the beat waits in the output register and the stages
// behind it keep filling until the chain is full; in_tready then falls.
// Reset empties the whole chain and loads the configuration reset values.
`default_nettype none
`include "svpwm_compare_generator_macros.svh"

module svpwm_compare_generator (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // v_alpha_mv [16:0], v_beta_mv [33:17], bus_mv [49:34], zero padding [55:50]
  input  wire logic [svcg_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Output stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // sector_num [2:0], active_time_one [18:3], active_time_two [34:19],
  // zero_time [50:35], compare_u [66:51], compare_v [82:67], compare_w [98:83],
  // window_one [114:99], window_two [130:115], sample_compare [146:131],
  // midpoint_flag [147], trusted_phases [149:148], zero padding [151:150]
  output logic [svcg_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // Configuration write port
  input  wire logic                               cfg_we,
  input  wire logic [2:0]                         cfg_index,
  input  wire logic [svcg_pkg::CFG_W-1:0]         cfg_data
);
  import svcg_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0] period_r;
  logic [CFG_W-1:0] min_cmp_r;
  logic [CFG_W-1:0] max_cmp_r;
  logic [CFG_W-1:0] trig_off_r;
  logic [CFG_W-1:0] def_bus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= 16'd4250;
      min_cmp_r  <= 16'd0;
      max_cmp_r  <= 16'd4250;
      trig_off_r <= 16'd0;
      def_bus_r  <= 16'd24000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERIOD: period_r   <= cfg_data;
        CFG_MIN:    min_cmp_r  <= cfg_data;
        CFG_MAX:    max_cmp_r  <= cfg_data;
        CFG_TRIG:   trig_off_r <= cfg_data;
        CFG_DEFBUS: def_bus_r  <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Stage readiness, from the output back to the input.
  logic rdy_p, rdy_a, rdy_b, rdy_m, rdy_n, rdy_f, rdy_o;

  // ---------------------------------------------------------------------------
  // Input stage: unpack, pre-rotate into the right half plane, substitute the bus.
  // ---------------------------------------------------------------------------
  logic signed [VIN_W-1:0] in_a;
  logic signed [VIN_W-1:0] in_b;
  logic [BUS_W-1:0]        in_bus;
  logic signed [XY_W-1:0]  ax_ext;
  logic signed [XY_W-1:0]  by_ext;
  logic                    p_v_r;
  cordic_t                 p_r;
  cordic_t                 p_nxt;

  assign in_a   = in_tdata[16:0];
  assign in_b   = in_tdata[33:17];
  assign in_bus = in_tdata[49:34];

  always_comb begin
    ax_ext = {{(XY_W-VIN_W){in_a[VIN_W-1]}}, in_a} <<< CORDIC_STAGES;
    by_ext = {{(XY_W-VIN_W){in_b[VIN_W-1]}}, in_b} <<< CORDIC_STAGES;
    p_nxt.a = in_a;
    p_nxt.b = in_b;
    if (ax_ext[XY_W-1]) begin
      p_nxt.x = -ax_ext;
      p_nxt.y = -by_ext;
      p_nxt.z = 32'h8000_0000;
    end else begin
      p_nxt.x = ax_ext;
      p_nxt.y = by_ext;
      p_nxt.z = '0;
    end
    if (in_bus > LOW_BUS_MV) begin
      p_nxt.bus = in_bus;
    end else if (def_bus_r == '0) begin
      p_nxt.bus = 16'd1;
    end else begin
      p_nxt.bus = def_bus_r;
    end
  end

  logic c_ready [0:CORDIC_STAGES];

  assign rdy_p     = !p_v_r || c_ready[0];
  assign in_tready = rdy_p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (rdy_p) begin
      p_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_p && in_tvalid) begin
      p_r <= p_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC chain: one cell per iteration.
  // ---------------------------------------------------------------------------
  logic    c_valid [0:CORDIC_STAGES];
  cordic_t c_data  [0:CORDIC_STAGES];

  assign c_valid[0]             = p_v_r;
  assign c_data[0]              = p_r;
  assign c_ready[CORDIC_STAGES] = rdy_a;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    svcg_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (IDX_W'(k)),
      .in_valid  (c_valid[k]),
      .in_ready  (c_ready[k]),
      .in_data   (c_data[k]),
      .out_valid (c_valid[k+1]),
      .out_ready (c_ready[k+1]),
      .out_data  (c_data[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage A: exact angles on the axes, sector, and the projection products.
  // ---------------------------------------------------------------------------
  cordic_t                  c_last;
  logic [TURN_W-1:0]        z_fix;
  logic [ANGLE_BITS-1:0]    ang;
  logic [ANGLE_BITS+2:0]    six_ang;
  logic [2:0]               sec_raw;
  logic signed [PROJ_W-1:0] a_wide;
  logic signed [PROJ_W-1:0] b_wide;
  logic signed [PROJ_W-1:0] k_wide;

  logic                     a_v_r;
  logic [2:0]               a_sector_r, a_sector_nxt;
  logic signed [PROJ_W-1:0] a_sb_r, a_sb_nxt;
  logic signed [PROJ_W-1:0] a_a3_r, a_a3_nxt;
  logic [BUS_W-1:0]         a_bus_r;

  assign c_last = c_data[CORDIC_STAGES];

  always_comb begin
    if (c_last.b == '0) begin
      z_fix = c_last.a[VIN_W-1] ? 32'h8000_0000 : 32'h0000_0000;
    end else if (c_last.a == '0) begin
      z_fix = c_last.b[VIN_W-1] ? 32'hC000_0000 : 32'h4000_0000;
    end else begin
      z_fix = c_last.z;
    end
    ang          = z_fix[TURN_W-1 -: ANGLE_BITS];
    six_ang      = (ANGLE_BITS+3)'(ang) * (ANGLE_BITS+3)'(6);
    sec_raw      = six_ang[ANGLE_BITS+2:ANGLE_BITS];
    a_sector_nxt = (sec_raw > 3'd5) ? 3'd6 : sec_raw + 3'd1;
    a_wide       = {{(PROJ_W-VIN_W){c_last.a[VIN_W-1]}}, c_last.a};
    b_wide       = {{(PROJ_W-VIN_W){c_last.b[VIN_W-1]}}, c_last.b};
    k_wide       = {{(PROJ_W-18){1'b0}}, SQRT3_Q16};
    a_sb_nxt     = b_wide * k_wide;
    a_a3_nxt     = (a_wide <<< 17) + (a_wide <<< 16);
  end

  assign rdy_a = !a_v_r || rdy_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (rdy_a) begin
      a_v_r <= c_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && c_valid[CORDIC_STAGES]) begin
      a_sector_r <= a_sector_nxt;
      a_sb_r     <= a_sb_nxt;
      a_a3_r     <= a_a3_nxt;
      a_bus_r    <= c_last.bus;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: sector projections, duty numerators and the common divisor.
  // ---------------------------------------------------------------------------
  function automatic logic [Q_W-1:0] pos_q(input logic signed [PROJ_W-1:0] v);
    logic [Q_W-1:0] r;
    if (!v[PROJ_W-1] && (v != '0)) begin
      r = v[Q_W-1:0];
    end else begin
      r = '0;
    end
    return r;
  endfunction

  logic signed [PROJ_W-1:0] prj_x;
  logic signed [PROJ_W-1:0] prj_y;
  logic signed [PROJ_W-1:0] prj_z;
  logic [D_W-1:0]           q_sum;
  logic [D_W-1:0]           bus_d;

  logic                     b_v_r;
  logic [Q_W-1:0]           b_q1_r, b_q1_nxt;
  logic [Q_W-1:0]           b_q2_r, b_q2_nxt;
  logic [D_W-1:0]           b_d_r, b_d_nxt;
  logic [2:0]               b_sector_r;

  always_comb begin
    prj_x = a_sb_r <<< 1;
    prj_y = a_a3_r + a_sb_r;
    prj_z = a_sb_r - a_a3_r;
    case (a_sector_r)
      3'd1: begin b_q1_nxt = pos_q(-prj_z); b_q2_nxt = pos_q(prj_x);  end
      3'd2: begin b_q1_nxt = pos_q(prj_y);  b_q2_nxt = pos_q(prj_z);  end
      3'd3: begin b_q1_nxt = pos_q(prj_x);  b_q2_nxt = pos_q(-prj_y); end
      3'd4: begin b_q1_nxt = pos_q(prj_z);  b_q2_nxt = pos_q(-prj_x); end
      3'd5: begin b_q1_nxt = pos_q(-prj_y); b_q2_nxt = pos_q(-prj_z); end
      default: begin b_q1_nxt = pos_q(-prj_x); b_q2_nxt = pos_q(prj_y); end
    endcase
    q_sum   = D_W'(b_q1_nxt) + D_W'(b_q2_nxt);
    bus_d   = D_W'({a_bus_r, {BUS_SHIFT{1'b0}}});
    b_d_nxt = (q_sum > bus_d) ? q_sum : bus_d;
  end

  assign rdy_b = !b_v_r || rdy_m;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (rdy_b) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && a_v_r) begin
      b_q1_r     <= b_q1_nxt;
      b_q2_r     <= b_q2_nxt;
      b_d_r      <= b_d_nxt;
      b_sector_r <= a_sector_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage M: period times numerator, split into two partial products per lane.
  // ---------------------------------------------------------------------------
  logic                   m_v_r;
  logic [CFG_W+QH_W-1:0]  m_p1h_r, m_p2h_r;
  logic [CFG_W+QL_W-1:0]  m_p1l_r, m_p2l_r;
  logic [D_W-1:0]         m_d_r;
  logic [2:0]             m_sector_r;

  assign rdy_m = !m_v_r || rdy_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (rdy_m) begin
      m_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_m && b_v_r) begin
      m_p1h_r    <= (CFG_W+QH_W)'(period_r) * (CFG_W+QH_W)'(b_q1_r[Q_W-1:QL_W]);
      m_p2h_r    <= (CFG_W+QH_W)'(period_r) * (CFG_W+QH_W)'(b_q2_r[Q_W-1:QL_W]);
      m_p1l_r    <= (CFG_W+QL_W)'(period_r) * (CFG_W+QL_W)'(b_q1_r[QL_W-1:0]);
      m_p2l_r    <= (CFG_W+QL_W)'(period_r) * (CFG_W+QL_W)'(b_q2_r[QL_W-1:0]);
      m_d_r      <= b_d_r;
      m_sector_r <= b_sector_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage N: full products and the starting remainders of the divider.
  // ---------------------------------------------------------------------------
  localparam int TQ_W = CFG_W + Q_W + 1;

  logic [TQ_W-1:0] tq1;
  logic [TQ_W-1:0] tq2;
  logic            n_v_r;
  div_t            n_r;
  div_t            n_nxt;

  always_comb begin
    tq1 = (TQ_W'(m_p1h_r) << QL_W) + TQ_W'(m_p1l_r);
    tq2 = (TQ_W'(m_p2h_r) << QL_W) + TQ_W'(m_p2l_r);
    // The dividend is the product shifted up by the fraction bits; its upper part
    // is already below the divisor because every quotient fits the time width.
    n_nxt.rem1   = D_W'(tq1 >> CFG_W);
    n_nxt.rem2   = D_W'(tq2 >> CFG_W);
    n_nxt.nq1    = {tq1[CFG_W-1:0], {FRAC_BITS{1'b0}}};
    n_nxt.nq2    = {tq2[CFG_W-1:0], {FRAC_BITS{1'b0}}};
    n_nxt.dvs    = m_d_r;
    n_nxt.sector = m_sector_r;
  end

  logic d_ready [0:TIME_W];

  assign rdy_n = !n_v_r || d_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_v_r <= 1'b0;
    end else if (rdy_n) begin
      n_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_n && m_v_r) begin
      n_r <= n_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider chain: one cell per quotient bit.
  // ---------------------------------------------------------------------------
  logic d_valid [0:TIME_W];
  div_t d_data  [0:TIME_W];

  assign d_valid[0]      = n_v_r;
  assign d_data[0]       = n_r;
  assign d_ready[TIME_W] = rdy_f;

  for (genvar k = 0; k < TIME_W; k++) begin : g_div
    svcg_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (d_valid[k]),
      .in_ready  (d_ready[k]),
      .in_data   (d_data[k]),
      .out_valid (d_valid[k+1]),
      .out_ready (d_ready[k+1]),
      .out_data  (d_data[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage F: zero time and the raw seven-segment phase compares.
  // ---------------------------------------------------------------------------
  div_t                d_last;
  logic [TIME_W-1:0]   full_t;
  logic [TIME_W-1:0]   t0_full;
  logic [TIME_W+1:0]   p1;
  logic [TIME_W+1:0]   p2;
  logic [TIME_W+1:0]   p12;
  logic [TIME_W+1:0]   h2;
  logic [TIME_W+1:0]   u2;
  logic [TIME_W+1:0]   v2;
  logic [TIME_W+1:0]   w2;

  logic                f_v_r;
  logic [2:0]          f_sector_r;
  logic [CFG_W-1:0]    f_t1_r, f_t2_r, f_t0_r;
  logic [CFG_W-1:0]    f_cu_r, f_cv_r, f_cw_r;

  assign d_last = d_data[TIME_W];

  always_comb begin
    full_t  = {period_r, {FRAC_BITS{1'b0}}};
    t0_full = full_t - d_last.nq1 - d_last.nq2;
    p1      = (TIME_W+2)'(d_last.nq1) << 1;
    p2      = (TIME_W+2)'(d_last.nq2) << 1;
    p12     = p1 + p2;
    h2      = (TIME_W+2)'(t0_full);
    case (d_last.sector)
      3'd1:    begin u2 = p12 + h2; v2 = p2 + h2;  w2 = h2;       end
      3'd2:    begin u2 = p1 + h2;  v2 = p12 + h2; w2 = h2;       end
      3'd3:    begin u2 = h2;       v2 = p12 + h2; w2 = p2 + h2;  end
      3'd4:    begin u2 = h2;       v2 = p1 + h2;  w2 = p12 + h2; end
      3'd5:    begin u2 = p2 + h2;  v2 = h2;       w2 = p12 + h2; end
      default: begin u2 = p12 + h2; v2 = h2;       w2 = p1 + h2;  end
    endcase
  end

  assign rdy_f = !f_v_r || rdy_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (rdy_f) begin
      f_v_r <= d_valid[TIME_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_f && d_valid[TIME_W]) begin
      f_sector_r <= d_last.sector;
      f_t1_r     <= d_last.nq1[TIME_W-1:FRAC_BITS];
      f_t2_r     <= d_last.nq2[TIME_W-1:FRAC_BITS];
      f_t0_r     <= t0_full[TIME_W-1:FRAC_BITS];
      f_cu_r     <= u2[TIME_W:FRAC_BITS+1];
      f_cv_r     <= v2[TIME_W:FRAC_BITS+1];
      f_cw_r     <= w2[TIME_W:FRAC_BITS+1];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: clamping, sampling windows, trigger compare, phase pair.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]   cu_c, cv_c, cw_c;
  logic [CFG_W-1:0]   centre;
  logic [CFG_W-1:0]   win_x, win_y;
  logic signed [CFG_W+1:0] samp_sum;
  logic [CFG_W-1:0]   samp_c;
  pair_t              pair_c;

  logic               o_v_r;
  logic [2:0]         o_sector_r;
  logic [CFG_W-1:0]   o_t1_r, o_t2_r, o_t0_r;
  logic [CFG_W-1:0]   o_cu_r, o_cv_r, o_cw_r;
  logic [CFG_W-1:0]   o_win1_r, o_win1_nxt;
  logic [CFG_W-1:0]   o_win2_r, o_win2_nxt;
  logic [CFG_W-1:0]   o_samp_r;
  logic               o_mid_r;
  pair_t              o_pair_r;

  always_comb begin
    cu_c   = clamp_cmp(f_cu_r, min_cmp_r, max_cmp_r);
    cv_c   = clamp_cmp(f_cv_r, min_cmp_r, max_cmp_r);
    cw_c   = clamp_cmp(f_cw_r, min_cmp_r, max_cmp_r);
    centre = {1'b0, period_r[CFG_W-1:1]};
    case (f_sector_r)
      3'd1, 3'd6: begin win_x = cv_c; win_y = cw_c; pair_c = PAIR_VW; end
      3'd2, 3'd3: begin win_x = cu_c; win_y = cw_c; pair_c = PAIR_UW; end
      default:    begin win_x = cu_c; win_y = cv_c; pair_c = PAIR_UV; end
    endcase
    o_win1_nxt = (win_x >= centre) ? win_x - centre : centre - win_x;
    o_win2_nxt = (win_y >= centre) ? win_y - centre : centre - win_y;
    // Trigger point: half period plus the signed offset, then clamped.
    samp_sum = $signed({2'b00, centre}) + $signed({{2{trig_off_r[CFG_W-1]}}, trig_off_r});
    if (samp_sum < $signed({2'b00, min_cmp_r})) begin
      samp_c = min_cmp_r;
    end else if (samp_sum > $signed({2'b00, max_cmp_r})) begin
      samp_c = max_cmp_r;
    end else begin
      samp_c = samp_sum[CFG_W-1:0];
    end
  end

  assign rdy_o = !o_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (rdy_o) begin
      o_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && f_v_r) begin
      o_sector_r <= f_sector_r;
      o_t1_r     <= f_t1_r;
      o_t2_r     <= f_t2_r;
      o_t0_r     <= f_t0_r;
      o_cu_r     <= cu_c;
      o_cv_r     <= cv_c;
      o_cw_r     <= cw_c;
      o_win1_r   <= o_win1_nxt;
      o_win2_r   <= o_win2_nxt;
      o_samp_r   <= samp_c;
      o_mid_r    <= (trig_off_r == '0);
      o_pair_r   <= pair_c;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = {2'b00, o_pair_r, o_mid_r, o_samp_r, o_win2_r, o_win1_r,
                       o_cw_r, o_cv_r, o_cu_r, o_t0_r, o_t2_r, o_t1_r, o_sector_r};

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `SVCG_ASSERT_NOW(a_sector_range, o_v_r, (o_sector_r >= 3'd1) && (o_sector_r <= 3'd6))
  `SVCG_ASSERT_NOW(a_pair_vw, o_v_r && ((o_sector_r == 3'd1) || (o_sector_r == 3'd6)), o_pair_r == PAIR_VW)
  `SVCG_ASSERT_NEXT(a_f_holds, f_v_r && !rdy_o, f_v_r)

endmodule

`default_nettype wire
